FILE: hdl/length_prefixed_table_parser_defines.svh
// Assertion macros for the length-prefixed table parser.
// Used by the top level; expects clk and rst in scope.
`ifndef LENGTH_PREFIXED_TABLE_PARSER_DEFINES_SVH
`define LENGTH_PREFIXED_TABLE_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define LPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lpt_pkg.sv
// Shared types and codes of the length-prefixed table parser.
// No dependencies; imported by every module.
`timescale 1ns / 1ps

package lpt_pkg;

  // Status codes of a finish result
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_MARKER = 3'd1;
  localparam logic [2:0] ST_ROWS      = 3'd2;
  localparam logic [2:0] ST_CELLS     = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  // Result kinds
  localparam logic EV_CELL   = 1'b0;
  localparam logic EV_FINISH = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH_MODE = 2'd0;
  localparam logic [1:0] CFG_ROW_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_COL_LIMIT  = 2'd2;

  // Byte value of a row-marker token byte
  localparam logic [7:0] MARKER_BYTE = 8'hFF;

  // Result queue geometry; a request may push two results
  localparam int RES_DEPTH    = 8;
  localparam int RES_AW       = $clog2(RES_DEPTH);
  localparam int RES_CW       = $clog2(RES_DEPTH + 1);
  localparam int SLOT_RESERVE = 2;

  typedef struct packed {
    logic        event_kind;
    logic [2:0]  status;
    logic [15:0] row_index;
    logic [15:0] col_index;
    logic [31:0] data_offset;
    logic [63:0] cell_length;
    logic        final_result;
  } result_t;

  // Up to two results produced by one request, first slot filled first
  typedef struct packed {
    logic    va;
    logic    vb;
    result_t a;
    result_t b;
  } push_t;

  typedef struct packed {
    logic [1:0]  length_width_mode;
    logic [15:0] row_limit;
    logic [15:0] col_limit;
  } cfg_t;

endpackage

FILE: hdl/lpt_channels.sv
// Handshake channels of the length-prefixed table parser: input bytes,
// results and configuration writes.
`timescale 1ns / 1ps

interface lpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface lpt_out_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [2:0]  status;
  logic [15:0] row_index;
  logic [15:0] col_index;
  logic [31:0] data_offset;
  logic [63:0] cell_length;
  logic        final_result;
  modport source (output valid, event_kind, status, row_index, col_index, data_offset,
                  cell_length, final_result, input ready);
  modport sink (input valid, event_kind, status, row_index, col_index, data_offset,
                cell_length, final_result, output ready);
endinterface

interface lpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] value;
  modport source (output valid, index, value, input ready);
  modport sink (input valid, index, value, output ready);
endinterface

FILE: hdl/lpt_result_fifo.sv
// Result queue: takes up to two results per cycle, releases one.
// Depends on lpt_pkg.
`timescale 1ns / 1ps

module lpt_result_fifo
  import lpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  push_t             push,
  input  logic              pop,
  output logic              not_empty,
  output logic [RES_CW-1:0] count,
  output result_t           head_res
);

  result_t           mem [RES_DEPTH];
  logic [RES_AW-1:0] head;
  logic [RES_AW-1:0] tail;
  logic [RES_AW-1:0] tail_b;
  logic [RES_CW-1:0] push_n;
  logic [RES_CW-1:0] pop_n;

  assign tail_b    = tail + RES_AW'(1);
  assign push_n    = RES_CW'(push.va) + RES_CW'(push.vb);
  assign pop_n     = RES_CW'(pop);
  assign not_empty = (count != '0);
  assign head_res  = mem[head];

  // Store pushed results at the tail
  always_ff @(posedge clk) begin
    if (push.va) begin
      mem[tail] <= push.a;
    end
    if (push.vb) begin
      mem[tail_b] <= push.b;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + push_n[RES_AW-1:0];
      head  <= head + RES_AW'(pop);
      count <= count + push_n - pop_n;
    end
  end

endmodule

FILE: hdl/lpt_parse_core.sv
// Input register and per-byte token parser of the table body.
// Depends on lpt_pkg; feeds lpt_result_fifo.
`timescale 1ns / 1ps

module lpt_parse_core
  import lpt_pkg::*;
#(
  parameter longint unsigned MAX_DIMENSION = 65535,
  parameter int              OFFSET_BITS   = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       busy,
  output push_t      push
);

  localparam logic [31:0] MAX_DIM_W = 32'(MAX_DIMENSION);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Stream state
  logic                   in_cell, in_cell_next;
  logic [3:0]             tok_count, tok_count_next;
  logic [63:0]            acc, acc_next;
  logic                   all_ones, all_ones_next;
  logic [63:0]            left, left_next;
  logic                   row_started, row_started_next;
  logic [15:0]            row, row_next;
  logic [16:0]            col, col_next;
  logic [OFFSET_BITS-1:0] offset, offset_next;
  logic [2:0]             err, err_next;

  // Working values
  logic [15:0]            row_cap;
  logic [15:0]            col_cap;
  logic [3:0]             width;
  logic [3:0]             cnt_tmp;
  logic [63:0]            acc_tmp;
  logic                   ones_tmp;
  logic [OFFSET_BITS-1:0] off_inc;
  logic [63:0]            off_wide;
  logic                   cell_hit;
  logic                   finish;
  logic [2:0]             fin_status;
  result_t                cell_res;
  result_t                fin_res;

  assign busy = s1_valid;

  // Cap limits at the configured maximum dimension
  always_comb begin
    row_cap = ({16'd0, cfg.row_limit} > MAX_DIM_W) ? MAX_DIM_W[15:0] : cfg.row_limit;
    col_cap = ({16'd0, cfg.col_limit} > MAX_DIM_W) ? MAX_DIM_W[15:0] : cfg.col_limit;
  end

  assign width    = 4'd1 << cfg.length_width_mode;
  assign off_inc  = offset + OFFSET_BITS'(1);
  assign off_wide = 64'(off_inc);

  // Register the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  // Parse one byte: skip cell data or collect a length token
  always_comb begin
    in_cell_next     = in_cell;
    tok_count_next   = tok_count;
    acc_next         = acc;
    all_ones_next    = all_ones;
    left_next        = left;
    row_started_next = row_started;
    row_next         = row;
    col_next         = col;
    offset_next      = offset;
    err_next         = err;
    cnt_tmp          = tok_count + 4'd1;
    acc_tmp          = acc | (64'(s1_byte) << {tok_count[2:0], 3'b000});
    ones_tmp         = all_ones & (s1_byte == MARKER_BYTE);
    cell_hit         = 1'b0;
    finish           = 1'b0;
    fin_status       = ST_OK;

    if (s1_valid) begin
      if (err == ST_OK) begin
        if (in_cell) begin
          left_next = left - 64'd1;
          if (left_next == 64'd0) begin
            in_cell_next = 1'b0;
          end
        end else if (cnt_tmp >= width) begin
          if (ones_tmp) begin
            if (!row_started) begin
              if (row_cap == 16'd0) begin
                err_next = ST_ROWS;
              end else begin
                row_started_next = 1'b1;
                row_next         = 16'd0;
                col_next         = 17'd0;
              end
            end else if (({1'b0, row} + 17'd1) >= {1'b0, row_cap}) begin
              err_next = ST_ROWS;
            end else begin
              row_next = row + 16'd1;
              col_next = 17'd0;
            end
          end else if (!row_started) begin
            err_next = ST_NO_MARKER;
          end else if (col >= {1'b0, col_cap}) begin
            err_next = ST_CELLS;
          end else begin
            cell_hit = 1'b1;
            col_next = col + 17'd1;
            if (acc_tmp != 64'd0) begin
              in_cell_next = 1'b1;
              left_next    = acc_tmp;
            end
          end
          tok_count_next = 4'd0;
          acc_next       = 64'd0;
          all_ones_next  = 1'b1;
        end else begin
          tok_count_next = cnt_tmp;
          acc_next       = acc_tmp;
          all_ones_next  = ones_tmp;
        end
      end

      offset_next = off_inc;

      // End of stream: report status, drop stream state
      if (s1_last) begin
        finish = 1'b1;
        if (err_next != ST_OK) begin
          fin_status = err_next;
        end else if ((tok_count_next != 4'd0) || in_cell_next) begin
          fin_status = ST_TRUNC;
        end
        in_cell_next     = 1'b0;
        tok_count_next   = 4'd0;
        acc_next         = 64'd0;
        all_ones_next    = 1'b1;
        left_next        = 64'd0;
        row_started_next = 1'b0;
        row_next         = 16'd0;
        col_next         = 17'd0;
        offset_next      = '0;
        err_next         = ST_OK;
      end
    end
  end

  // Build results and order them into the push slots
  always_comb begin
    cell_res.event_kind   = EV_CELL;
    cell_res.status       = ST_OK;
    cell_res.row_index    = row;
    cell_res.col_index    = col[15:0];
    cell_res.data_offset  = off_wide[31:0];
    cell_res.cell_length  = acc_tmp;
    cell_res.final_result = !finish;

    fin_res.event_kind   = EV_FINISH;
    fin_res.status       = fin_status;
    fin_res.row_index    = 16'd0;
    fin_res.col_index    = 16'd0;
    fin_res.data_offset  = 32'd0;
    fin_res.cell_length  = 64'd0;
    fin_res.final_result = 1'b1;

    push.va = cell_hit | finish;
    push.vb = cell_hit & finish;
    push.a  = cell_hit ? cell_res : fin_res;
    push.b  = fin_res;
  end

  // Stream state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_cell     <= 1'b0;
      tok_count   <= 4'd0;
      acc         <= 64'd0;
      all_ones    <= 1'b1;
      left        <= 64'd0;
      row_started <= 1'b0;
      row         <= 16'd0;
      col         <= 17'd0;
      offset      <= '0;
      err         <= ST_OK;
    end else begin
      in_cell     <= in_cell_next;
      tok_count   <= tok_count_next;
      acc         <= acc_next;
      all_ones    <= all_ones_next;
      left        <= left_next;
      row_started <= row_started_next;
      row         <= row_next;
      col         <= col_next;
      offset      <= offset_next;
      err         <= err_next;
    end
  end

endmodule

FILE: hdl/length_prefixed_table_parser.sv
// Top level of the length-prefixed table parser: configuration registers,
// parse core and result queue. Depends on lpt_pkg, lpt_channels and the defines header.
`timescale 1ns / 1ps
`include "length_prefixed_table_parser_defines.svh"

// Takes one body byte per cycle and reports each cell (row, column, offset of its
// first data byte, declared length) and, on the byte marked last, a finish result
// with the stream status. A byte is parsed in the cycle after it is taken; its
// results enter an eight-entry queue and leave it one per cycle while the sink
// takes them. Bytes are taken every cycle as long as the queue keeps room for two
// results of the byte in flight and two of the next; a byte yields at most two
// results, so only a sink that stalls slows the input. Configuration writes are
// taken in any cycle and belong between streams. No clearing pass is needed after
// reset.
module length_prefixed_table_parser
  import lpt_pkg::*;
#(
  parameter longint unsigned MAX_DIMENSION = 65535,
  parameter int              OFFSET_BITS   = 32
) (
  input logic        clk,
  input logic        rst,
  lpt_in_if.sink     body_ch,
  lpt_out_if.source  result_ch,
  lpt_cfg_if.sink    cfg
);

  localparam logic [RES_CW-1:0] PUSH_ROOM = RES_CW'(RES_DEPTH - SLOT_RESERVE);

  cfg_t              cfg_regs;
  push_t             push;
  logic              in_accept;
  logic              out_pop;
  logic              core_busy;
  logic              res_valid;
  logic [RES_CW-1:0] res_count;
  logic [RES_CW:0]   res_need;
  logic              pair_ok;
  result_t           head_res;

  // Write configuration registers; other indexes are ignored
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.length_width_mode <= 2'd0;
      cfg_regs.row_limit         <= 16'd1;
      cfg_regs.col_limit         <= 16'd1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_WIDTH_MODE: cfg_regs.length_width_mode <= cfg.value[1:0];
        CFG_ROW_LIMIT:  cfg_regs.row_limit         <= cfg.value;
        CFG_COL_LIMIT:  cfg_regs.col_limit         <= cfg.value;
        default: ;
      endcase
    end
  end

  // Accept a request while the queue has room for everything in flight
  assign res_need = {1'b0, res_count} + (core_busy ? (RES_CW + 1)'(2 * SLOT_RESERVE)
                                                   : (RES_CW + 1)'(SLOT_RESERVE));
  assign body_ch.ready = (res_need <= (RES_CW + 1)'(RES_DEPTH));
  assign in_accept     = body_ch.valid & body_ch.ready;

  lpt_parse_core #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .accept    (in_accept),
    .data_byte (body_ch.data_byte),
    .last_byte (body_ch.last_byte),
    .busy      (core_busy),
    .push      (push)
  );

  assign out_pop = result_ch.valid & result_ch.ready;

  lpt_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (out_pop),
    .not_empty (res_valid),
    .count     (res_count),
    .head_res  (head_res)
  );

  // Drive the result channel from the queue head
  assign result_ch.valid        = res_valid;
  assign result_ch.event_kind   = head_res.event_kind;
  assign result_ch.status       = head_res.status;
  assign result_ch.row_index    = head_res.row_index;
  assign result_ch.col_index    = head_res.col_index;
  assign result_ch.data_offset  = head_res.data_offset;
  assign result_ch.cell_length  = head_res.cell_length;
  assign result_ch.final_result = head_res.final_result;

  // A pair of results is always a cell followed by the finish
  assign pair_ok = push.va && (push.a.event_kind == EV_CELL)
                   && (push.b.event_kind == EV_FINISH);

  // Checks on queue space and result ordering
  `LPT_ASSERT_NOW(a_queue_bound, 1'b1, res_count <= RES_CW'(RES_DEPTH), "result queue overflow")
  `LPT_ASSERT_NOW(a_pair_order, push.vb, pair_ok, "result pair out of order")
  `LPT_ASSERT_NOW(a_push_space, push.va, res_count <= PUSH_ROOM, "push without queue room")
  `LPT_ASSERT_NEXT(a_accept_busy, in_accept, core_busy, "accepted byte not held for parsing")

endmodule
